// ===== hw/rtl/ppt_pkg.sv =====
// Shared constants for the promotable priority table: request and status codes,
// default sizes and the control bundle passed to the best-entry tracker.
// No dependencies.
package ppt_pkg;

    localparam int TABLE_DEPTH_DEF    = 64;
    localparam int PAYLOAD_WIDTH_DEF  = 32;
    localparam int PRIORITY_WIDTH_DEF = 16;

    localparam int STAMP_WIDTH  = 32;
    localparam int REQ_WIDTH    = 2;
    localparam int STATUS_WIDTH = 3;

    localparam logic [REQ_WIDTH-1:0] REQ_ADD     = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_PROMOTE = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_POP     = 2'd2;
    localparam logic [REQ_WIDTH-1:0] REQ_CHECK   = 2'd3;

    localparam logic [STATUS_WIDTH-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY     = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] STAT_BAD_ID    = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] STAT_SATURATED = 3'd4;
    localparam logic [STATUS_WIDTH-1:0] STAT_SEQ_DONE  = 3'd5;

    typedef struct packed {
        logic clear;
        logic valid;
    } ppt_scan_ctl_t;

endpackage

// ===== hw/rtl/ppt_mem.sv =====
// Entry store of the priority table: one write port, one registered read port.
// No dependencies.
module ppt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 81
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ppt_best.sv =====
// Running best-entry tracker used by pop: one priority/stamp compare per cycle.
// Depends on ppt_pkg.
module ppt_best #(
    parameter int ID_WIDTH       = 6,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ppt_pkg::ppt_scan_ctl_t         ctl,
    input  logic                           ent_used,
    input  logic [PRIORITY_WIDTH-1:0]      ent_prio,
    input  logic [ppt_pkg::STAMP_WIDTH-1:0] ent_stamp,
    input  logic [PAYLOAD_WIDTH-1:0]       ent_payload,
    input  logic [ID_WIDTH-1:0]            ent_addr,
    output logic                           found,
    output logic [PRIORITY_WIDTH-1:0]      best_prio,
    output logic [ppt_pkg::STAMP_WIDTH-1:0] best_stamp,
    output logic [PAYLOAD_WIDTH-1:0]       best_payload,
    output logic [ID_WIDTH-1:0]            best_addr
);
    import ppt_pkg::*;

    logic                      found_reg, found_next;
    logic [PRIORITY_WIDTH-1:0] prio_reg, prio_next;
    logic [STAMP_WIDTH-1:0]    stamp_reg, stamp_next;
    logic [PAYLOAD_WIDTH-1:0]  payload_reg, payload_next;
    logic [ID_WIDTH-1:0]       addr_reg, addr_next;
    logic                      take;

    assign take = ctl.valid && ent_used &&
                  (!found_reg || (ent_prio > prio_reg) ||
                   ((ent_prio == prio_reg) && (ent_stamp < stamp_reg)));

    always_comb
    begin
        found_next   = found_reg;
        prio_next    = prio_reg;
        stamp_next   = stamp_reg;
        payload_next = payload_reg;
        addr_next    = addr_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next   = 1'b1;
            prio_next    = ent_prio;
            stamp_next   = ent_stamp;
            payload_next = ent_payload;
            addr_next    = ent_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        stamp_reg   <= stamp_next;
        payload_reg <= payload_next;
        addr_reg    <= addr_next;
    end

    assign found        = found_reg;
    assign best_prio    = prio_reg;
    assign best_stamp   = stamp_reg;
    assign best_payload = payload_reg;
    assign best_addr    = addr_reg;

endmodule

// ===== hw/rtl/promotable_priority_table.sv =====
// Promotable priority table: sequencer, entry store and best-entry tracker.
// Promote and check read the addressed entry; add scans from slot 0 up to the lowest free slot;
// pop scans every entry; requests refused from the request alone (full, empty, bad id, stamps used up) skip the scan.
// One request at a time; add and pop scan the single memory read port one entry a cycle.
// After reset a clearing pass over all TABLE_DEPTH entries runs before the first request is taken.
// Depends on ppt_pkg, ppt_mem and ppt_best.
module promotable_priority_table #(
    parameter int TABLE_DEPTH    = ppt_pkg::TABLE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH  = ppt_pkg::PAYLOAD_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = ppt_pkg::PRIORITY_WIDTH_DEF,
    localparam int IDW    = $clog2(TABLE_DEPTH),
    localparam int IN_W   = PAYLOAD_WIDTH + IDW,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = ppt_pkg::STATUS_WIDTH + IDW + PAYLOAD_WIDTH + PRIORITY_WIDTH + 1,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // payload_in, slot_id_in (lowest bit up)
    input  logic [IN_TW-1:0]              s_tdata,
    // req_type
    input  logic [ppt_pkg::REQ_WIDTH-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, slot_id_out, payload_out, priority_out, id_held (lowest bit up)
    output logic [OUT_TW-1:0]             m_tdata
);
    import ppt_pkg::*;

    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = 1 + PRIORITY_WIDTH + STAMP_WIDTH + PAYLOAD_WIDTH;
    localparam int PR_LO  = 1;
    localparam int ST_LO  = PR_LO + PRIORITY_WIDTH;
    localparam int PY_LO  = ST_LO + STAMP_WIDTH;
    localparam logic [IDW-1:0] LAST_ADDR = IDW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_POPWR = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [IDW-1:0]           scan_addr_reg, scan_addr_next;
    logic                     scan_issue_reg, scan_issue_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [IDW-1:0]           rd_addr_reg, rd_addr_next;
    logic [STAMP_WIDTH-1:0]   stamp_reg, stamp_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    logic [REQ_WIDTH-1:0]     req_reg, req_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [STATUS_WIDTH-1:0]  res_status_reg, res_status_next;
    logic [IDW-1:0]           res_slot_reg, res_slot_next;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg, res_pay_next;
    logic [PRIORITY_WIDTH-1:0] res_prio_reg, res_prio_next;
    logic                     res_held_reg, res_held_next;
    logic [OUT_TW-1:0]        m_tdata_reg, m_tdata_next;

    logic                     in_fire;
    logic [PAYLOAD_WIDTH-1:0] in_pay;
    logic [IDW-1:0]           in_id;
    logic                     in_id_ok;

    logic                     wr_en;
    logic [IDW-1:0]           wr_addr;
    logic [WORD_W-1:0]        wr_data;
    logic [IDW-1:0]           rd_addr;
    logic [WORD_W-1:0]        rd_data;

    logic                      rd_used;
    logic [PRIORITY_WIDTH-1:0] rd_prio;
    logic [STAMP_WIDTH-1:0]    rd_stamp;
    logic [PAYLOAD_WIDTH-1:0]  rd_pay;

    ppt_scan_ctl_t             scan_ctl;
    logic                      best_found;
    logic [PRIORITY_WIDTH-1:0] best_prio;
    logic [STAMP_WIDTH-1:0]    best_stamp;
    logic [PAYLOAD_WIDTH-1:0]  best_payload;
    logic [IDW-1:0]            best_addr;

    assign in_pay   = s_tdata[PAYLOAD_WIDTH-1:0];
    assign in_id    = s_tdata[IN_W-1:PAYLOAD_WIDTH];
    assign in_id_ok = {1'b0, in_id} < (IDW + 1)'(TABLE_DEPTH);
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign rd_used  = rd_data[0];
    assign rd_prio  = rd_data[ST_LO-1:PR_LO];
    assign rd_stamp = rd_data[PY_LO-1:ST_LO];
    assign rd_pay   = rd_data[WORD_W-1:PY_LO];

    assign rd_addr = (state_reg == S_IDLE) ? in_id : scan_addr_reg;

    ppt_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ppt_best #(
        .ID_WIDTH       (IDW),
        .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_best (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .ent_used     (rd_used),
        .ent_prio     (rd_prio),
        .ent_stamp    (rd_stamp),
        .ent_payload  (rd_pay),
        .ent_addr     (rd_addr_reg),
        .found        (best_found),
        .best_prio    (best_prio),
        .best_stamp   (best_stamp),
        .best_payload (best_payload),
        .best_addr    (best_addr)
    );

    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        scan_issue_next = scan_issue_reg;
        rd_valid_next   = 1'b0;
        rd_addr_next    = rd_addr_reg;
        stamp_next      = stamp_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg;
        req_next        = req_reg;
        pay_next        = pay_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pay_next    = res_pay_reg;
        res_prio_next   = res_prio_reg;
        res_held_next   = res_held_reg;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_addr_reg;
        wr_data         = '0;
        scan_ctl.clear  = 1'b0;
        scan_ctl.valid  = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = scan_addr_reg;
                wr_data = '0;
                if (scan_addr_reg == LAST_ADDR)
                begin
                    scan_addr_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next        = s_tuser;
                    pay_next        = in_pay;
                    rd_addr_next    = in_id;
                    res_status_next = STAT_OK;
                    res_slot_next   = '0;
                    res_pay_next    = '0;
                    res_prio_next   = '0;
                    res_held_next   = 1'b0;
                    scan_addr_next  = '0;
                    case (s_tuser)
                        REQ_ADD:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = S_OUT;
                            end
                            else if (stamp_reg == '1)
                            begin
                                res_status_next = STAT_SEQ_DONE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                scan_issue_next = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                scan_ctl.clear  = 1'b1;
                                scan_issue_next = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (in_id_ok)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_status_next = STAT_BAD_ID;
                                state_next      = S_OUT;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_issue_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = scan_addr_reg;
                    if (scan_addr_reg == LAST_ADDR)
                    begin
                        scan_issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end
                end
                if (rd_valid_reg)
                begin
                    if (req_reg == REQ_ADD)
                    begin
                        if (!rd_used)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = rd_addr_reg;
                            wr_data         = {pay_reg, stamp_reg, PRIORITY_WIDTH'(0), 1'b1};
                            stamp_next      = stamp_reg + 1'b1;
                            count_next      = count_reg + 1'b1;
                            res_slot_next   = rd_addr_reg;
                            scan_issue_next = 1'b0;
                            rd_valid_next   = 1'b0;
                            state_next      = S_OUT;
                        end
                        else if (rd_addr_reg == LAST_ADDR)
                        begin
                            res_status_next = STAT_FULL;
                            scan_issue_next = 1'b0;
                            rd_valid_next   = 1'b0;
                            state_next      = S_OUT;
                        end
                    end
                    else
                    begin
                        scan_ctl.valid = 1'b1;
                        if (rd_addr_reg == LAST_ADDR)
                        begin
                            rd_valid_next = 1'b0;
                            state_next    = S_POPWR;
                        end
                    end
                end
            end
            S_POPWR:
            begin
                if (best_found)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = best_addr;
                    wr_data       = {best_payload, best_stamp, best_prio, 1'b0};
                    count_next    = count_reg - 1'b1;
                    res_slot_next = best_addr;
                    res_pay_next  = best_payload;
                    res_prio_next = best_prio;
                end
                else
                begin
                    res_status_next = STAT_EMPTY;
                end
                state_next = S_OUT;
            end
            S_READ:
            begin
                if (!rd_used)
                begin
                    res_status_next = STAT_BAD_ID;
                end
                else if (req_reg == REQ_CHECK)
                begin
                    res_held_next = 1'b1;
                    res_pay_next  = rd_pay;
                    res_prio_next = rd_prio;
                end
                else if (rd_prio == '1)
                begin
                    res_status_next = STAT_SATURATED;
                end
                else if (stamp_reg == '1)
                begin
                    res_status_next = STAT_SEQ_DONE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_addr_reg;
                    wr_data    = {rd_pay, stamp_reg, rd_prio + 1'b1, 1'b1};
                    stamp_next = stamp_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TW'({res_held_reg, res_prio_reg, res_pay_reg,
                                             res_slot_reg, res_status_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            scan_addr_reg  <= '0;
            scan_issue_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            stamp_reg      <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_addr_reg  <= scan_addr_next;
            scan_issue_reg <= scan_issue_next;
            rd_valid_reg   <= rd_valid_next;
            stamp_reg      <= stamp_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        req_reg        <= req_next;
        pay_reg        <= pay_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_pay_reg    <= res_pay_next;
        res_prio_reg   <= res_prio_next;
        res_held_reg   <= res_held_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/ppt_result_checker.sv =====
// Result checker for the promotable priority table: watches both stream channels,
// keeps its own copy of the slot table and compares every result field by field.
// Depends on ppt_pkg.
module ppt_result_checker #(
    parameter int TABLE_DEPTH    = ppt_pkg::TABLE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH  = ppt_pkg::PAYLOAD_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = ppt_pkg::PRIORITY_WIDTH_DEF,
    localparam int IDW    = $clog2(TABLE_DEPTH),
    localparam int IN_TW  = ((PAYLOAD_WIDTH + IDW + 7) / 8) * 8,
    localparam int OUT_W  = ppt_pkg::STATUS_WIDTH + IDW + PAYLOAD_WIDTH + PRIORITY_WIDTH + 1,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [IN_TW-1:0]              s_tdata,
    input  logic [ppt_pkg::REQ_WIDTH-1:0] s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [OUT_TW-1:0]             m_tdata,
    output int                            fail_count,
    output int                            outstanding
);
    import ppt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFS_SLOT = STATUS_WIDTH;
    localparam int OFS_PAY  = OFS_SLOT + IDW;
    localparam int OFS_LVL  = OFS_PAY + PAYLOAD_WIDTH;
    localparam int OFS_HELD = OFS_LVL + PRIORITY_WIDTH;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]   status;
        logic [IDW-1:0]            slot;
        logic [PAYLOAD_WIDTH-1:0]  payload;
        logic [PRIORITY_WIDTH-1:0] level;
        logic                      held;
    } table_result_t;

    logic                      slot_used    [TABLE_DEPTH];
    logic [PRIORITY_WIDTH-1:0] slot_level   [TABLE_DEPTH];
    logic [STAMP_WIDTH-1:0]    slot_stamp   [TABLE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0]  slot_payload [TABLE_DEPTH];
    logic [STAMP_WIDTH-1:0]    stamp_next;
    int                        held_count;
    int                        results_seen;
    table_result_t             expected_results [$];

    function automatic table_result_t apply_request(input logic [REQ_WIDTH-1:0] kind,
                                                    input logic [PAYLOAD_WIDTH-1:0] pay,
                                                    input logic [IDW-1:0] id);
        table_result_t r;
        int            best;
        bit            hit;
        bit            id_live;
        r       = '0;
        best    = 0;
        hit     = 1'b0;
        id_live = (int'(id) < TABLE_DEPTH) && slot_used[id];
        case (kind)
            REQ_ADD:
            begin
                if (held_count >= TABLE_DEPTH)
                    r.status = STAT_FULL;
                else if (stamp_next == '1)
                    r.status = STAT_SEQ_DONE;
                else
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (!hit && !slot_used[i])
                        begin
                            best = i;
                            hit  = 1'b1;
                        end
                    end
                    slot_used[best]    = 1'b1;
                    slot_level[best]   = '0;
                    slot_stamp[best]   = stamp_next;
                    slot_payload[best] = pay;
                    stamp_next         = stamp_next + 1'b1;
                    held_count++;
                    r.slot = best[IDW-1:0];
                end
            end
            REQ_PROMOTE:
            begin
                if (!id_live)
                    r.status = STAT_BAD_ID;
                else if (slot_level[id] == '1)
                    r.status = STAT_SATURATED;
                else if (stamp_next == '1)
                    r.status = STAT_SEQ_DONE;
                else
                begin
                    slot_level[id] = slot_level[id] + 1'b1;
                    slot_stamp[id] = stamp_next;
                    stamp_next     = stamp_next + 1'b1;
                end
            end
            REQ_POP:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot_used[i] && (!hit || slot_level[i] > slot_level[best] ||
                        (slot_level[i] == slot_level[best] &&
                         slot_stamp[i] < slot_stamp[best])))
                    begin
                        best = i;
                        hit  = 1'b1;
                    end
                end
                if (!hit)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.slot          = best[IDW-1:0];
                    r.payload       = slot_payload[best];
                    r.level         = slot_level[best];
                    slot_used[best] = 1'b0;
                    if (held_count > 0)
                        held_count--;
                end
            end
            default:
            begin
                if (!id_live)
                    r.status = STAT_BAD_ID;
                else
                begin
                    r.held    = 1'b1;
                    r.payload = slot_payload[id];
                    r.level   = slot_level[id];
                end
            end
        endcase
        r.status = r.status;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_TW-1:0] got,
                                   input logic [OUT_TW-1:0] want);
        $display("%0t ns: result %0d, %s: got 0x%0h, want 0x%0h",
                 $realtime, results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic compare_result(input logic [OUT_TW-1:0] word);
        table_result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with no request outstanding", word, '0);
            return;
        end
        want = expected_results.pop_front();
        if (word[STATUS_WIDTH-1:0] !== want.status)
            report_mismatch("status", OUT_TW'(word[STATUS_WIDTH-1:0]),
                            OUT_TW'(want.status));
        if (word[OFS_SLOT +: IDW] !== want.slot)
            report_mismatch("slot_id_out", OUT_TW'(word[OFS_SLOT +: IDW]),
                            OUT_TW'(want.slot));
        if (word[OFS_PAY +: PAYLOAD_WIDTH] !== want.payload)
            report_mismatch("payload_out", OUT_TW'(word[OFS_PAY +: PAYLOAD_WIDTH]),
                            OUT_TW'(want.payload));
        if (word[OFS_LVL +: PRIORITY_WIDTH] !== want.level)
            report_mismatch("priority_out", OUT_TW'(word[OFS_LVL +: PRIORITY_WIDTH]),
                            OUT_TW'(want.level));
        if (word[OFS_HELD] !== want.held)
            report_mismatch("id_held", OUT_TW'(word[OFS_HELD]), OUT_TW'(want.held));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_used[i] = 1'b0;
            stamp_next   = '0;
            held_count   = 0;
            results_seen = 0;
            fail_count   = 0;
            outstanding  = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                                        apply_request(s_tuser, s_tdata[PAYLOAD_WIDTH-1:0],
                                                      s_tdata[PAYLOAD_WIDTH +: IDW]));
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_promotable_priority_table.sv =====
// Testbench top for the promotable priority table: clock, reset, request stimulus
// with random idling on both channels, and the final verdict.
// Depends on ppt_pkg, promotable_priority_table and ppt_result_checker.
module tb_promotable_priority_table;

    import ppt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int PW        = PAYLOAD_WIDTH_DEF;
    localparam int PRW       = PRIORITY_WIDTH_DEF;
    localparam int IDW       = $clog2(DEPTH);
    localparam int IN_TW     = ((PW + IDW + 7) / 8) * 8;
    localparam int OUT_TW    = ((STATUS_WIDTH + IDW + PW + PRW + 1 + 7) / 8) * 8;
    localparam int HOLD_LEN  = 400;

    typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} phase_mode_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_TW-1:0]     s_tdata  = '0;
    logic [REQ_WIDTH-1:0] s_tuser  = REQ_ADD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_TW-1:0]    m_tdata;
    int                   fail_count;
    int                   outstanding;
    bit                   quiet        = 1'b1;
    bit                   hold_request = 1'b0;

    promotable_priority_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ppt_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_request(input logic [REQ_WIDTH-1:0] kind, input logic [PW-1:0] pay,
                                 input logic [IDW-1:0] id);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata             = '0;
        s_tdata[PW-1:0]     = pay;
        s_tdata[PW +: IDW]  = id;
        s_tuser             = kind;
        s_tvalid            = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready     = 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (!quiet)
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        phase_mode_t          mode;
        int                   r;
        logic [REQ_WIDTH-1:0] kind;
        logic [PW-1:0]        pay;
        logic [IDW-1:0]       id;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        issue_request(REQ_CHECK,   '0, '0);
        issue_request(REQ_POP,     '0, '0);
        issue_request(REQ_PROMOTE, '0, 6'd5);
        issue_request(REQ_ADD,     32'h0000_0000, '0);
        issue_request(REQ_ADD,     32'hFFFF_FFFF, '1);
        issue_request(REQ_ADD,     32'hA5A5_5A5A, '0);
        issue_request(REQ_ADD,     32'h1234_5678, '0);
        issue_request(REQ_PROMOTE, '0, 6'd2);
        issue_request(REQ_PROMOTE, '1, 6'd1);
        issue_request(REQ_CHECK,   '0, 6'd1);
        issue_request(REQ_CHECK,   '0, '1);
        issue_request(REQ_PROMOTE, '0, '1);
        issue_request(REQ_POP,     '0, '0);
        issue_request(REQ_POP,     '0, '0);
        issue_request(REQ_ADD,     32'hDEAD_BEEF, '0);
        issue_request(REQ_POP,     '0, '0);
        issue_request(REQ_POP,     '0, '0);
        issue_request(REQ_POP,     '0, '0);
        issue_request(REQ_POP,     '0, '0);

        // drive one entry up a few levels, then check and drop it
        issue_request(REQ_ADD, 32'h0F0F_F0F0, '0);
        for (int k = 0; k < 8; k++)
            issue_request(REQ_PROMOTE, $urandom, '0);
        issue_request(REQ_PROMOTE, '0, '0);
        issue_request(REQ_CHECK,   '0, '0);
        issue_request(REQ_POP,     '0, '0);

        for (int seg = 0; seg < 20; seg++)
        begin
            mode  = phase_mode_t'(seg % 3);
            quiet = (seg % 4 == 3);
            for (int n = 0; n < 80; n++)
            begin
                if (seg == 10 && n == 20)
                    hold_request = 1'b1;
                r = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        kind = (r < 60) ? REQ_ADD : (r < 75) ? REQ_PROMOTE :
                               (r < 85) ? REQ_POP : REQ_CHECK;
                    MODE_MIXED:
                        kind = (r < 30) ? REQ_ADD : (r < 55) ? REQ_PROMOTE :
                               (r < 80) ? REQ_POP : REQ_CHECK;
                    default:
                        kind = (r < 10) ? REQ_ADD : (r < 25) ? REQ_PROMOTE :
                               (r < 85) ? REQ_POP : REQ_CHECK;
                endcase
                r = $urandom_range(0, 99);
                pay = (r < 8) ? '0 : (r < 16) ? '1 : PW'($urandom);
                id  = $urandom_range(0, 1) ? IDW'($urandom_range(0, 15))
                                           : IDW'($urandom_range(0, DEPTH - 1));
                issue_request(kind, pay, id);
            end
        end
        s_tvalid = 1'b0;
        quiet    = 1'b1;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DEPTH + 8) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
